FILE: src/c02pd_pkg.sv
// Package for the 65C02 instruction predecoder.
// Holds the addressing-mode codes, opcode constants, the opcode matrix and the result type.
// No dependencies.
package c02pd_pkg;

  // Addressing-mode codes as reported on the result channel.
  typedef enum logic [4:0] {
    AM_IMP = 5'd0,
    AM_ACC = 5'd1,
    AM_IMM = 5'd2,
    AM_ZP  = 5'd3,
    AM_ZPX = 5'd4,
    AM_ZPY = 5'd5,
    AM_IZX = 5'd6,
    AM_IZY = 5'd7,
    AM_IZP = 5'd8,
    AM_ABS = 5'd9,
    AM_ABX = 5'd10,
    AM_ABY = 5'd11,
    AM_IND = 5'd12,
    AM_IAX = 5'd13,
    AM_REL = 5'd14,
    AM_ZPR = 5'd15,
    AM_ILL = 5'd16
  } addr_mode_t;

  // Opcodes that need special handling beyond their addressing mode.
  localparam logic [7:0] OPC_BRK     = 8'h00;
  localparam logic [7:0] OPC_JSR     = 8'h20;
  localparam logic [7:0] OPC_RTI     = 8'h40;
  localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
  localparam logic [7:0] OPC_RTS     = 8'h60;
  localparam logic [7:0] OPC_JMP_IND = 8'h6C;
  localparam logic [7:0] OPC_JMP_IAX = 8'h7C;
  localparam logic [7:0] OPC_BRA     = 8'h80;
  localparam logic [7:0] OPC_STP     = 8'hDB;

  // Full opcode matrix, indexed by the opcode byte. Undefined opcodes map to AM_ILL.
  localparam addr_mode_t MODE_TABLE [256] = '{
    AM_IMP, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_ACC, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ZP,  AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_ACC, AM_ILL, AM_ABS, AM_ABX, AM_ABX, AM_ZPR,
    AM_ABS, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_ACC, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_ACC, AM_ILL, AM_ABX, AM_ABX, AM_ABX, AM_ZPR,
    AM_IMP, AM_IZX, AM_ILL, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_ACC, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ILL, AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_ILL, AM_ILL, AM_ABX, AM_ABX, AM_ZPR,
    AM_IMP, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_ACC, AM_ILL, AM_IND, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_ILL, AM_IAX, AM_ABX, AM_ABX, AM_ZPR,
    AM_REL, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_IMP, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_ILL, AM_ABS, AM_ABX, AM_ABX, AM_ZPR,
    AM_IMM, AM_IZX, AM_IMM, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_IMP, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_ILL, AM_ABX, AM_ABX, AM_ABY, AM_ZPR,
    AM_IMM, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_IMP, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ILL, AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_IMP, AM_ILL, AM_ABX, AM_ABX, AM_ZPR,
    AM_IMM, AM_IZX, AM_ILL, AM_ILL, AM_ZP,  AM_ZP,  AM_ZP,  AM_ZP,
    AM_IMP, AM_IMM, AM_IMP, AM_ILL, AM_ABS, AM_ABS, AM_ABS, AM_ZPR,
    AM_REL, AM_IZY, AM_IZP, AM_ILL, AM_ILL, AM_ZPX, AM_ZPX, AM_ZP,
    AM_IMP, AM_ABY, AM_IMP, AM_ILL, AM_ILL, AM_ABX, AM_ABX, AM_ZPR
  };

  // Instruction length in bytes for each addressing mode.
  function automatic logic [1:0] mode_length(input addr_mode_t mode);
    logic [1:0] len;
    case (mode)
      AM_IMP, AM_ACC, AM_ILL: len = 2'd1;
      AM_ABS, AM_ABX, AM_ABY, AM_IND, AM_IAX, AM_ZPR: len = 2'd3;
      default: len = 2'd2;
    endcase
    return len;
  endfunction

  // One decoded instruction.
  typedef struct packed {
    logic [1:0]  instr_length;
    addr_mode_t  addr_mode;
    logic        is_illegal;
    logic        is_halt;
    logic        is_relative;
    logic        is_jump;
    logic        is_conditional;
    logic        is_call;
    logic        is_return;
    logic [15:0] flow_target;
  } result_t;

endpackage

FILE: src/c02pd_in_if.sv
// Instruction channel of the 65C02 predecoder: address and three instruction bytes.
// Depends on nothing.
interface c02pd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_addr;
  logic [7:0]  opcode_byte;
  logic [7:0]  operand_low;
  logic [7:0]  operand_high;

  modport source (output valid, instr_addr, opcode_byte, operand_low, operand_high,
                  input ready);
  modport sink (input valid, instr_addr, opcode_byte, operand_low, operand_high,
                output ready);
endinterface

FILE: src/c02pd_out_if.sv
// Result channel of the 65C02 predecoder: length, addressing mode, flow flags, target.
// Depends on nothing.
interface c02pd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  instr_length;
  logic [4:0]  addr_mode;
  logic        is_illegal;
  logic        is_halt;
  logic        is_relative;
  logic        is_jump;
  logic        is_conditional;
  logic        is_call;
  logic        is_return;
  logic [15:0] flow_target;

  modport source (output valid, instr_length, addr_mode, is_illegal, is_halt, is_relative,
                  is_jump, is_conditional, is_call, is_return, flow_target,
                  input ready);
  modport sink (input valid, instr_length, addr_mode, is_illegal, is_halt, is_relative,
                is_jump, is_conditional, is_call, is_return, flow_target,
                output ready);
endinterface

FILE: src/c02pd_decode.sv
// Combinational decode of one 65C02 instruction into a c02pd_pkg::result_t.
// Depends on c02pd_pkg.
module c02pd_decode (
  input  logic [15:0]          instr_addr,
  input  logic [7:0]           opcode_byte,
  input  logic [7:0]           operand_low,
  input  logic [7:0]           operand_high,
  output c02pd_pkg::result_t   decoded
);

  c02pd_pkg::addr_mode_t mode;
  logic [15:0] word;
  logic [15:0] rel_target;
  logic [15:0] bit_target;
  logic [15:0] target;

  // Opcode matrix lookup.
  assign mode = c02pd_pkg::MODE_TABLE[opcode_byte];
  assign word = {operand_high, operand_low};

  // Branch targets wrap at 16 bits.
  assign rel_target = instr_addr + 16'd2 + {{8{operand_low[7]}}, operand_low};
  assign bit_target = instr_addr + 16'd3 + {{8{operand_high[7]}}, operand_high};

  // Flow classification follows the addressing mode first, then specific opcodes.
  always_comb begin
    decoded = '0;
    decoded.instr_length = c02pd_pkg::mode_length(mode);
    decoded.addr_mode = mode;
    target = '0;
    if (mode == c02pd_pkg::AM_ILL) begin
      decoded.is_illegal = 1'b1;
      decoded.is_halt = 1'b1;
    end else if (mode == c02pd_pkg::AM_REL) begin
      decoded.is_relative = 1'b1;
      decoded.is_jump = 1'b1;
      decoded.is_conditional = (opcode_byte != c02pd_pkg::OPC_BRA);
      target = rel_target;
    end else if (mode == c02pd_pkg::AM_ZPR) begin
      decoded.is_relative = 1'b1;
      decoded.is_jump = 1'b1;
      decoded.is_conditional = 1'b1;
      target = bit_target;
    end else if (opcode_byte == c02pd_pkg::OPC_JSR) begin
      decoded.is_call = 1'b1;
      target = word;
    end else if (opcode_byte == c02pd_pkg::OPC_JMP_ABS ||
                 opcode_byte == c02pd_pkg::OPC_JMP_IND ||
                 opcode_byte == c02pd_pkg::OPC_JMP_IAX) begin
      decoded.is_jump = 1'b1;
      target = word;
    end else if (opcode_byte == c02pd_pkg::OPC_RTI ||
                 opcode_byte == c02pd_pkg::OPC_RTS) begin
      decoded.is_return = 1'b1;
    end else if (opcode_byte == c02pd_pkg::OPC_BRK ||
                 opcode_byte == c02pd_pkg::OPC_STP) begin
      decoded.is_halt = 1'b1;
    end
    decoded.flow_target = target;
  end

endmodule

FILE: src/cmos_6502_instruction_predecode_core.sv
// 65C02 instruction predecoder, top level.
// Each instruction passes the input register and then the result register.
// Throughput: one instruction per cycle while result.ready is not held low; the opcode table
// lookup and the two 16-bit branch-target adds sit between the two registers.
// Reset: synchronous active-high rst empties both stages; no results are pending after it.
module cmos_6502_instruction_predecode_core (
  input  logic               clk,
  input  logic               rst,
  c02pd_in_if.sink           instr,
  c02pd_out_if.source        result
);

  logic               stage_valid;
  logic [15:0]        stage_addr;
  logic [7:0]         stage_opcode;
  logic [7:0]         stage_low;
  logic [7:0]         stage_high;
  logic               out_valid;
  c02pd_pkg::result_t out_data;
  c02pd_pkg::result_t decoded;
  logic               advance;

  // The result register can take a new value when empty or when its transaction completes.
  assign advance = !out_valid || result.ready;
  assign instr.ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (instr.ready) begin
      stage_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.ready && instr.valid) begin
      stage_addr   <= instr.instr_addr;
      stage_opcode <= instr.opcode_byte;
      stage_low    <= instr.operand_low;
      stage_high   <= instr.operand_high;
    end
  end

  c02pd_decode u_decode (
    .instr_addr   (stage_addr),
    .opcode_byte  (stage_opcode),
    .operand_low  (stage_low),
    .operand_high (stage_high),
    .decoded      (decoded)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_data <= decoded;
    end
  end

  // Drive the result channel.
  assign result.valid          = out_valid;
  assign result.instr_length   = out_data.instr_length;
  assign result.addr_mode      = out_data.addr_mode;
  assign result.is_illegal     = out_data.is_illegal;
  assign result.is_halt        = out_data.is_halt;
  assign result.is_relative    = out_data.is_relative;
  assign result.is_jump        = out_data.is_jump;
  assign result.is_conditional = out_data.is_conditional;
  assign result.is_call        = out_data.is_call;
  assign result.is_return      = out_data.is_return;
  assign result.flow_target    = out_data.flow_target;

  // In the cycle after reset no result may be pending.
  assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // Undefined opcodes are single-byte halting entries with no target.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_illegal) |->
      (result.instr_length == 2'd1 && result.is_halt && result.flow_target == 16'd0))
    else $error("illegal opcode decoded inconsistently");

  // The target is only reported for jumps and calls.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.is_jump && !result.is_call) |-> result.flow_target == 16'd0)
    else $error("target set on a non-transfer instruction");

  // Conditional branches are relative, and relative branches are jumps.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_conditional) |-> (result.is_relative && result.is_jump))
    else $error("conditional flag without a relative branch");

  // A held input stage must still be there once the result register drains.
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid)
    else $error("input stage lost an item under backpressure");

endmodule
